FILE: hw/rtl/pbrs_pkg.sv
// shared types and constants for the per-bank refresh scheduler
package pbrs_pkg;

    localparam int DEF_MAX_LEVELS = 4;
    localparam int HW_LEVELS      = 4;

    localparam int INTERVAL_W  = 20;
    localparam int LVL_CNT_W   = 3;
    localparam int SIZE_W      = 5;
    localparam int CHAN_W      = 4;
    localparam int BANK_W      = 16;
    localparam int TOTAL_W     = BANK_W + 1;
    localparam int DIGIT_W     = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = INTERVAL_W;

    localparam int SIZE_LIMIT  = 16;

    localparam logic [INTERVAL_W-1:0] RST_REFRESH_INTERVAL = INTERVAL_W'(7800);
    localparam logic [LVL_CNT_W-1:0]  RST_LEVEL_COUNT      = LVL_CNT_W'(2);
    localparam logic [SIZE_W-1:0]     RST_LEVEL1_SIZE      = SIZE_W'(4);
    localparam logic [SIZE_W-1:0]     RST_LEVEL2_SIZE      = SIZE_W'(4);
    localparam logic [SIZE_W-1:0]     RST_LEVEL3_SIZE      = SIZE_W'(1);
    localparam logic [SIZE_W-1:0]     RST_LEVEL4_SIZE      = SIZE_W'(1);
    localparam logic [CHAN_W-1:0]     RST_CHANNEL_NUMBER   = CHAN_W'(0);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REFRESH_INTERVAL = 3'd0,
        CFG_LEVEL_COUNT      = 3'd1,
        CFG_LEVEL1_SIZE      = 3'd2,
        CFG_LEVEL2_SIZE      = 3'd3,
        CFG_LEVEL3_SIZE      = 3'd4,
        CFG_LEVEL4_SIZE      = 3'd5,
        CFG_CHANNEL_NUMBER   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PRODUCT,
        SEQ_DIVIDE
    } seq_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0]                 refresh_channel;
        logic [BANK_W-1:0]                 flat_bank;
        logic [HW_LEVELS-1:0][DIGIT_W-1:0] coord;
    } result_t;

endpackage

FILE: hw/rtl/per_bank_refresh_scheduler.sv
// per-bank refresh pacing with round-robin bank index and mixed-radix coordinates
// a triggering tick registers its beat in a two-entry output buffer that keeps s_ready
// off m_ready; it takes one tick per cycle unless busy or the skid entry is full
// after reset and after every mapped register write, s_ready stays low while one
// multiply per level forms the bank count, then a serial divider yields one quotient bit
// per cycle; synchronous active-low reset restores the register defaults and restarts
module per_bank_refresh_scheduler
    import pbrs_pkg::*;
#(
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_advance,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CHAN_W-1:0]      m_refresh_channel,
    output logic [BANK_W-1:0]      m_flat_bank,
    output logic [DIGIT_W-1:0]     m_coord_level1,
    output logic [DIGIT_W-1:0]     m_coord_level2,
    output logic [DIGIT_W-1:0]     m_coord_level3,
    output logic [DIGIT_W-1:0]     m_coord_level4
);

    localparam int LVL_W = $clog2(MAX_LEVELS + 1);
    localparam int DIV_W = $clog2(INTERVAL_W);

    // configuration registers
    logic [INTERVAL_W-1:0] refresh_interval_reg;
    logic [LVL_CNT_W-1:0]  level_count_reg;
    logic [SIZE_W-1:0]     size_reg [HW_LEVELS];
    logic [CHAN_W-1:0]     channel_number_reg;

    // restart sequencer
    seq_state_t            state_reg, state_next;
    logic                  busy;
    logic                  product_en;
    logic                  divide_en;
    logic                  product_last;
    logic                  divide_last;
    logic [LVL_W-1:0]      step_reg;
    logic [DIV_W-1:0]      div_cnt_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    rem_reg;
    logic [INTERVAL_W-1:0] quot_reg;

    // schedule state
    logic [INTERVAL_W-1:0] pacing_reg;
    logic [INTERVAL_W-1:0] cycles_reg;
    logic [BANK_W-1:0]     bank_reg;
    logic [DIGIT_W-1:0]    digits_reg [MAX_LEVELS];
    logic [DIGIT_W-1:0]    digits_next [MAX_LEVELS];

    // output buffer
    logic                  m_valid_reg;
    logic                  skid_valid_reg;
    result_t               main_reg;
    result_t               skid_reg;

    logic                  cfg_hit;
    logic                  in_beat;
    logic                  fire;
    logic                  pop;
    logic [LVL_W-1:0]      eff_levels;
    logic [SIZE_W-1:0]     eff_size [MAX_LEVELS];
    logic [SIZE_W-1:0]     step_size;
    logic [TOTAL_W+SIZE_W-1:0] product;
    logic [TOTAL_W:0]      rem_shift;
    logic                  quot_bit;
    logic [TOTAL_W-1:0]    rem_new;
    logic [INTERVAL_W-1:0] quot_new;
    logic [INTERVAL_W-1:0] pacing_new;
    logic [TOTAL_W-1:0]    bank_inc;
    logic [BANK_W-1:0]     bank_next;
    logic [DIGIT_W-1:0]    coord_now [HW_LEVELS];
    result_t               result_new;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index <= CFG_INDEX_W'(CFG_CHANNEL_NUMBER));

    // effective level count and level sizes
    always_comb begin
        if (level_count_reg == '0) begin
            eff_levels = LVL_W'(1);
        end else if (int'(level_count_reg) > MAX_LEVELS) begin
            eff_levels = LVL_W'(MAX_LEVELS);
        end else begin
            eff_levels = LVL_W'(level_count_reg);
        end
    end

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_size
        if (g < HW_LEVELS) begin : g_reg
            assign eff_size[g] = (size_reg[g] == '0) ? SIZE_W'(1) :
                                 (int'(size_reg[g]) > SIZE_LIMIT) ? SIZE_W'(SIZE_LIMIT) :
                                 size_reg[g];
        end else begin : g_one
            assign eff_size[g] = SIZE_W'(1);
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        if (cfg_hit) begin
            state_next = SEQ_PRODUCT;
        end else begin
            unique case (state_reg)
                SEQ_IDLE:    state_next = SEQ_IDLE;
                SEQ_PRODUCT: if (product_last) state_next = SEQ_DIVIDE;
                SEQ_DIVIDE:  if (divide_last) state_next = SEQ_IDLE;
                default:     state_next = SEQ_IDLE;
            endcase
        end
    end

    // sequencer outputs
    always_comb begin
        busy       = 1'b1;
        product_en = 1'b0;
        divide_en  = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:    busy       = 1'b0;
            SEQ_PRODUCT: product_en = 1'b1;
            SEQ_DIVIDE:  divide_en  = 1'b1;
            default:     busy       = 1'b1;
        endcase
    end

    assign product_last = product_en && (step_reg == LVL_W'(MAX_LEVELS - 1));
    assign divide_last  = divide_en && (div_cnt_reg == DIV_W'(INTERVAL_W - 1));

    // bank count: one level per cycle, unused levels count as 1
    always_comb begin
        step_size = SIZE_W'(1);
        for (int j = 0; j < MAX_LEVELS; j++) begin
            if ((step_reg == LVL_W'(j)) && (LVL_W'(j) < eff_levels)) begin
                step_size = eff_size[j];
            end
        end
        product = {{SIZE_W{1'b0}}, total_reg} * {{TOTAL_W{1'b0}}, step_size};
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quot_reg[INTERVAL_W-1]};
        if (rem_shift >= {1'b0, total_reg}) begin
            quot_bit = 1'b1;
            rem_new  = TOTAL_W'(rem_shift - {1'b0, total_reg});
        end else begin
            quot_bit = 1'b0;
            rem_new  = rem_shift[TOTAL_W-1:0];
        end
        quot_new   = {quot_reg[INTERVAL_W-2:0], quot_bit};
        pacing_new = (quot_new == '0) ? INTERVAL_W'(1) : quot_new;
    end

    // handshakes
    assign s_ready = !busy && !skid_valid_reg;
    assign in_beat = s_valid && s_ready;
    assign fire    = in_beat && s_advance && (cycles_reg <= INTERVAL_W'(1));
    assign pop     = m_valid_reg && m_ready;

    // next bank and its digits
    always_comb begin
        logic                carry;
        logic [DIGIT_W:0]    digit_inc;
        carry     = 1'b1;
        digit_inc = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            digits_next[i] = digits_reg[i];
        end
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (carry && (LVL_W'(i) < eff_levels)) begin
                digit_inc = {1'b0, digits_reg[i]} + (DIGIT_W+1)'(1);
                if (digit_inc >= eff_size[i]) begin
                    digits_next[i] = '0;
                end else begin
                    digits_next[i] = digit_inc[DIGIT_W-1:0];
                    carry          = 1'b0;
                end
            end
        end
    end

    assign bank_inc  = {1'b0, bank_reg} + TOTAL_W'(1);
    assign bank_next = (bank_inc >= total_reg) ? '0 : bank_inc[BANK_W-1:0];

    for (genvar c = 0; c < HW_LEVELS; c++) begin : g_coord
        if (c < MAX_LEVELS) begin : g_used
            assign coord_now[c] = digits_reg[c];
        end else begin : g_zero
            assign coord_now[c] = '0;
        end
        assign result_new.coord[c] = coord_now[c];
    end

    assign result_new.refresh_channel = channel_number_reg;
    assign result_new.flat_bank       = bank_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_interval_reg <= RST_REFRESH_INTERVAL;
            level_count_reg      <= RST_LEVEL_COUNT;
            size_reg[0]          <= RST_LEVEL1_SIZE;
            size_reg[1]          <= RST_LEVEL2_SIZE;
            size_reg[2]          <= RST_LEVEL3_SIZE;
            size_reg[3]          <= RST_LEVEL4_SIZE;
            channel_number_reg   <= RST_CHANNEL_NUMBER;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_REFRESH_INTERVAL: refresh_interval_reg <= cfg_data;
                CFG_LEVEL_COUNT:      level_count_reg      <= cfg_data[LVL_CNT_W-1:0];
                CFG_LEVEL1_SIZE:      size_reg[0]          <= cfg_data[SIZE_W-1:0];
                CFG_LEVEL2_SIZE:      size_reg[1]          <= cfg_data[SIZE_W-1:0];
                CFG_LEVEL3_SIZE:      size_reg[2]          <= cfg_data[SIZE_W-1:0];
                CFG_LEVEL4_SIZE:      size_reg[3]          <= cfg_data[SIZE_W-1:0];
                CFG_CHANNEL_NUMBER:   channel_number_reg   <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and schedule state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_PRODUCT;
            step_reg    <= '0;
            div_cnt_reg <= '0;
            total_reg   <= TOTAL_W'(1);
            rem_reg     <= '0;
            quot_reg    <= '0;
            pacing_reg  <= INTERVAL_W'(1);
            cycles_reg  <= INTERVAL_W'(1);
            bank_reg    <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                digits_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_hit) begin
                step_reg    <= '0;
                div_cnt_reg <= '0;
                total_reg   <= TOTAL_W'(1);
                bank_reg    <= '0;
                for (int i = 0; i < MAX_LEVELS; i++) begin
                    digits_reg[i] <= '0;
                end
            end else begin
                if (product_en) begin
                    total_reg <= product[TOTAL_W-1:0];
                    step_reg  <= step_reg + LVL_W'(1);
                    if (product_last) begin
                        rem_reg     <= '0;
                        quot_reg    <= refresh_interval_reg;
                        div_cnt_reg <= '0;
                    end
                end
                if (divide_en) begin
                    rem_reg     <= rem_new;
                    quot_reg    <= quot_new;
                    div_cnt_reg <= div_cnt_reg + DIV_W'(1);
                    if (divide_last) begin
                        pacing_reg <= pacing_new;
                        cycles_reg <= pacing_new;
                    end
                end
                if (in_beat && s_advance) begin
                    if (fire) begin
                        cycles_reg <= pacing_reg;
                        bank_reg   <= bank_next;
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            digits_reg[i] <= digits_next[i];
                        end
                    end else begin
                        cycles_reg <= cycles_reg - INTERVAL_W'(1);
                    end
                end
            end
        end
    end

    // two-entry output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg) begin
                m_valid_reg <= fire;
            end else if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= fire;
                end else begin
                    m_valid_reg <= fire;
                end
            end else if (fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg) begin
            if (fire) main_reg <= result_new;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (fire) skid_reg <= result_new;
            end else if (fire) begin
                main_reg <= result_new;
            end
        end else if (fire) begin
            skid_reg <= result_new;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_refresh_channel = main_reg.refresh_channel;
    assign m_flat_bank       = main_reg.flat_bank;
    assign m_coord_level1    = main_reg.coord[0];
    assign m_coord_level2    = main_reg.coord[1];
    assign m_coord_level3    = main_reg.coord[2];
    assign m_coord_level4    = main_reg.coord[3];

    // skid entry only ever fills behind a held beat
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid without main entry");

    // countdown stays within the pacing interval once the sequencer is done
    a_countdown_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_IDLE) |->
            (pacing_reg != '0) && (cycles_reg != '0) && (cycles_reg <= pacing_reg))
        else $error("refresh countdown out of range");

    // round-robin index never reaches the bank count
    a_bank_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_IDLE) |-> ({1'b0, bank_reg} < total_reg))
        else $error("bank index beyond bank count");

    // a triggering tick always leaves a beat waiting
    a_fire_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("refresh beat lost");

endmodule

FILE: verif/per_bank_refresh_scheduler_test.sv
// self-checking testbench for the per-bank refresh scheduler: random ticks against a schedule model
`timescale 1ns / 1ps

module per_bank_refresh_scheduler_test
    import pbrs_pkg::*;
();

    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned TICK_TARGET   = 900;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_advance = 1'b0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [CHAN_W-1:0]      m_refresh_channel;
    logic [BANK_W-1:0]      m_flat_bank;
    logic [DIGIT_W-1:0]     m_coord_level1;
    logic [DIGIT_W-1:0]     m_coord_level2;
    logic [DIGIT_W-1:0]     m_coord_level3;
    logic [DIGIT_W-1:0]     m_coord_level4;

    per_bank_refresh_scheduler dut (.*);

    // register shadow and schedule model
    logic [INTERVAL_W-1:0] sch_interval;
    logic [LVL_CNT_W-1:0]  sch_levels;
    logic [SIZE_W-1:0]     sch_size [HW_LEVELS];
    logic [CHAN_W-1:0]     sch_channel;
    int unsigned           used_levels;
    int unsigned           banks_total;
    int unsigned           pace;
    int unsigned           countdown;
    int unsigned           next_bank;
    int unsigned           radix [DEF_MAX_LEVELS];
    int unsigned           digit [DEF_MAX_LEVELS];

    bit                    tick_q [$];
    result_t               refresh_q [$];

    bit                    src_idle;
    bit                    sink_idle;
    int unsigned           tick_gap;
    int unsigned           sink_gap;
    int unsigned           quiet;
    int unsigned           ticks_planned;
    int unsigned           ticks_sent;
    int unsigned           beats_seen;
    int unsigned           reg_writes;
    int unsigned           settings_run;
    int unsigned           mismatches;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned idle_span(input bit enable);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enable || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void restart_schedule();
        int unsigned s;
        int unsigned k;
        used_levels = (sch_levels == 0) ? 1 : sch_levels;
        if (used_levels > DEF_MAX_LEVELS)
            used_levels = DEF_MAX_LEVELS;
        banks_total = 1;
        for (k = 0; k < DEF_MAX_LEVELS; k++) begin
            s = 1;
            if (k < HW_LEVELS) begin
                s = sch_size[k];
                if (s < 1)
                    s = 1;
                if (s > SIZE_LIMIT)
                    s = SIZE_LIMIT;
            end
            radix[k] = s;
            if (k < used_levels)
                banks_total *= s;
            digit[k] = 0;
        end
        pace = sch_interval / banks_total;
        if (pace == 0)
            pace = 1;
        countdown = pace;
        next_bank = 0;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        bit mapped = 1'b1;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_REFRESH_INTERVAL: sch_interval = data;
            CFG_LEVEL_COUNT:      sch_levels   = data[LVL_CNT_W-1:0];
            CFG_LEVEL1_SIZE:      sch_size[0]  = data[SIZE_W-1:0];
            CFG_LEVEL2_SIZE:      sch_size[1]  = data[SIZE_W-1:0];
            CFG_LEVEL3_SIZE:      sch_size[2]  = data[SIZE_W-1:0];
            CFG_LEVEL4_SIZE:      sch_size[3]  = data[SIZE_W-1:0];
            CFG_CHANNEL_NUMBER:   sch_channel  = data[CHAN_W-1:0];
            default:              mapped = 1'b0;
        endcase
        // an index outside the map leaves the schedule running
        if (mapped)
            restart_schedule();
    endtask

    // wait until every tick is in and every refresh beat is out, then let the pipe drain
    task automatic settle();
        while (tick_q.size() != 0 || s_valid || refresh_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned adv_pct);
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
        repeat (n) tick_q.push_back($urandom_range(0, 99) < adv_pct);
        ticks_planned += n;
        settings_run++;
        settle();
    endtask

    // tick driver, also steps the schedule model on every accepted beat with s_advance set
    always @(posedge aclk) begin : tick_driver
        result_t     due;
        int unsigned lvl;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_advance <= 1'b0;
            tick_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                ticks_sent++;
                if (s_advance) begin
                    if (countdown > 1) begin
                        countdown--;
                    end else begin
                        countdown = pace;
                        due.refresh_channel = sch_channel;
                        due.flat_bank       = next_bank[BANK_W-1:0];
                        for (lvl = 0; lvl < HW_LEVELS; lvl++)
                            due.coord[lvl] = (lvl < used_levels) ? digit[lvl][DIGIT_W-1:0] : '0;
                        refresh_q.push_back(due);
                        next_bank++;
                        if (next_bank >= banks_total)
                            next_bank = 0;
                        // mixed-radix carry, innermost level last
                        lvl = used_levels;
                        while (lvl > 0) begin
                            lvl--;
                            digit[lvl]++;
                            if (digit[lvl] < radix[lvl])
                                break;
                            digit[lvl] = 0;
                        end
                    end
                end
            end
            if (!s_valid || s_ready) begin
                if (tick_gap != 0 || tick_q.size() == 0) begin
                    if (tick_gap != 0)
                        tick_gap--;
                    s_valid <= 1'b0;
                end else begin
                    s_valid   <= 1'b1;
                    s_advance <= tick_q.pop_front();
                    tick_gap = idle_span(src_idle);
                end
            end
        end
    end

    always @(posedge aclk) begin : refresh_monitor
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (refresh_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display(
                            "unexpected refresh beat: chan %0d bank %0d coords %0d/%0d/%0d/%0d",
                            m_refresh_channel, m_flat_bank, m_coord_level1,
                            m_coord_level2, m_coord_level3, m_coord_level4);
                end else begin
                    want = refresh_q.pop_front();
                    if (want.refresh_channel !== m_refresh_channel ||
                        want.flat_bank !== m_flat_bank ||
                        want.coord[0] !== m_coord_level1 || want.coord[1] !== m_coord_level2 ||
                        want.coord[2] !== m_coord_level3 || want.coord[3] !== m_coord_level4) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("refresh beat %0d: expected chan %0d bank %0d %s",
                                     beats_seen, want.refresh_channel, want.flat_bank,
                                     $sformatf("coords %0d/%0d/%0d/%0d", want.coord[0],
                                               want.coord[1], want.coord[2], want.coord[3]));
                            $display("    got chan %0d bank %0d coords %0d/%0d/%0d/%0d",
                                     m_refresh_channel, m_flat_bank, m_coord_level1,
                                     m_coord_level2, m_coord_level3, m_coord_level4);
                        end
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                sink_gap = idle_span(sink_idle);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: no beat on any channel for %0d cycles", QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned           r;
        int unsigned           k;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] word;

        sch_interval = RST_REFRESH_INTERVAL;
        sch_levels   = RST_LEVEL_COUNT;
        sch_size[0]  = RST_LEVEL1_SIZE;
        sch_size[1]  = RST_LEVEL2_SIZE;
        sch_size[2]  = RST_LEVEL3_SIZE;
        sch_size[3]  = RST_LEVEL4_SIZE;
        sch_channel  = RST_CHANNEL_NUMBER;
        restart_schedule();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults pace far apart, so a handful of ticks gives no beat
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b1);
        ticks_planned += 4;
        settings_run++;
        settle();

        // interval alone changes: one beat per advancing tick over the default 4x4 banks, wrapping at 16
        write_reg(CFG_REFRESH_INTERVAL, CFG_DATA_W'(16));
        repeat (17) tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        ticks_planned += 19;
        settings_run++;
        settle();

        // widest setting: full interval over 16x16x16x16 banks, top channel
        write_reg(CFG_REFRESH_INTERVAL, '1);
        write_reg(CFG_LEVEL_COUNT, CFG_DATA_W'(4));
        write_reg(CFG_LEVEL1_SIZE, CFG_DATA_W'(16));
        write_reg(CFG_LEVEL2_SIZE, CFG_DATA_W'(16));
        write_reg(CFG_LEVEL3_SIZE, CFG_DATA_W'(16));
        write_reg(CFG_LEVEL4_SIZE, CFG_DATA_W'(16));
        write_reg(CFG_CHANNEL_NUMBER, CFG_DATA_W'(15));
        run_phase(80, 100);

        // zero level count, zero size and zero interval all fall back to one
        write_reg(CFG_LEVEL_COUNT, '0);
        write_reg(CFG_LEVEL1_SIZE, '0);
        write_reg(CFG_REFRESH_INTERVAL, '0);
        run_phase(30, 80);

        // count and sizes above range clamp; interval below the bank count
        write_reg(CFG_LEVEL_COUNT, CFG_DATA_W'(7));
        write_reg(CFG_LEVEL1_SIZE, CFG_DATA_W'(31));
        write_reg(CFG_LEVEL2_SIZE, CFG_DATA_W'(17));
        write_reg(CFG_LEVEL3_SIZE, '0);
        write_reg(CFG_LEVEL4_SIZE, CFG_DATA_W'(2));
        write_reg(CFG_REFRESH_INTERVAL, CFG_DATA_W'(1));
        run_phase(60, 90);

        // write outside the map: schedule carries on where it was
        write_reg(CFG_UNMAPPED, '1);
        run_phase(30, 90);

        while (ticks_planned < TICK_TARGET) begin
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                pick = (r < 8) ? $urandom_range(1, 4) : ((r == 8) ? 0 : $urandom_range(5, 7));
                word = CFG_DATA_W'($urandom);
                word[LVL_CNT_W-1:0] = LVL_CNT_W'(pick);
                write_reg(CFG_LEVEL_COUNT, word);
            end
            for (k = 0; k < HW_LEVELS; k++) begin
                if ($urandom_range(0, 1)) begin
                    // mostly small radices so the digits carry often
                    r = $urandom_range(0, 9);
                    pick = (r < 7) ? $urandom_range(1, 3) :
                           (r == 7) ? 0 : (r == 8) ? $urandom_range(17, 31) : SIZE_LIMIT;
                    word = CFG_DATA_W'($urandom);
                    word[SIZE_W-1:0] = SIZE_W'(pick);
                    write_reg(CFG_INDEX_W'(CFG_LEVEL1_SIZE + k), word);
                end
            end
            if ($urandom_range(0, 1))
                write_reg(CFG_CHANNEL_NUMBER, CFG_DATA_W'($urandom));
            // interval last, sized from the bank count so the pacing stays short
            r = $urandom_range(0, 9);
            pick = (r < 2) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            write_reg(CFG_REFRESH_INTERVAL,
                      CFG_DATA_W'(banks_total * pick + $urandom_range(0, banks_total - 1)));
            run_phase($urandom_range(20, 80), $urandom_range(60, 100));
        end

        if (refresh_q.size() != 0)
            $display("%0d expected refresh beats never arrived", refresh_q.size());
        $display("run covered %0d ticks and %0d refresh beats under %0d settings",
                 ticks_sent, beats_seen, settings_run);
        $display("%0d register writes, %0d mismatching beats", reg_writes, mismatches);
        if (mismatches == 0 && refresh_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/pbrs_pkg.sv
hw/rtl/per_bank_refresh_scheduler.sv
verif/per_bank_refresh_scheduler_test.sv
